>>> rtl/bti_pkg.sv
// ----------------------------------------------------------------------------
// bti_pkg
// Shared widths, codes and interface structs of the breakpoint table
// interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package bti_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int ADDR_W      = $clog2(MAX_POINTS);
   localparam int IDX_W       = 6;
   localparam int COUNT_W     = 7;
   localparam int TEMP_W      = 32;
   localparam int ABS_W       = 48;
   localparam int DT_W        = TEMP_W + 1;
   localparam int DA_W        = ABS_W + 1;
   localparam int PROD_W      = DT_W + DA_W;
   localparam int QUO_W       = 40;
   localparam int SUM_W       = QUO_W + 2;
   localparam int MUL_LO_W    = 25;
   localparam int MUL_OUT_W   = DT_W + MUL_LO_W;
   localparam int DIV_CNT_W   = $clog2(QUO_W);
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_DESC_MODE   = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_SINGLE = 2'd2,
      STAT_EQUAL  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD_LO,
      ST_RD_HI,
      ST_DIFF,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_CHECK,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [TEMP_W-1:0] wtemp;
      logic [ABS_W-1:0]  wabsc;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic [TEMP_W-1:0] rtemp;
      logic [ABS_W-1:0]  rabsc;
   } mem_rsp_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DA_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> rtl/bti_table_mem.sv
// ----------------------------------------------------------------------------
// bti_table_mem
// Breakpoint storage: temperature and abscissa arrays, one write port and
// one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bti_table_mem (
   input  wire logic                 clock,
   input  wire bti_pkg::mem_req_type mem_req,
   output bti_pkg::mem_rsp_type      mem_rsp
);
   import bti_pkg::*;

   logic [TEMP_W-1:0] temp_mem [MAX_POINTS];
   logic [ABS_W-1:0]  absc_mem [MAX_POINTS];
   logic [TEMP_W-1:0] rtemp_ff;
   logic [ABS_W-1:0]  rabsc_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         temp_mem[mem_req.waddr] <= mem_req.wtemp;
         absc_mem[mem_req.waddr] <= mem_req.wabsc;
      end
   end

   always_ff @(posedge clock) begin
      rtemp_ff <= temp_mem[mem_req.raddr];
      rabsc_ff <= absc_mem[mem_req.raddr];
   end

   assign mem_rsp.rtemp = rtemp_ff;
   assign mem_rsp.rabsc = rabsc_ff;

endmodule

`default_nettype wire

>>> rtl/bti_divider.sv
// ----------------------------------------------------------------------------
// bti_divider
// Restoring divider, one quotient bit per cycle. The dividend is known to
// give a quotient below 2^QUO_W, so only the low quotient bits are formed.
// ----------------------------------------------------------------------------
`default_nettype none

module bti_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bti_pkg::div_req_type div_req,
   output bti_pkg::div_rsp_type      div_rsp
);
   import bti_pkg::*;

   logic                 run_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DA_W-1:0]      rem_ff;
   logic [DA_W-1:0]      dsr_ff;
   logic [QUO_W-1:0]     low_ff;
   logic [DA_W:0]        trial;
   logic [DA_W:0]        diff;
   logic                 qbit;
   logic [DA_W-1:0]      rem_in;
   logic                 last_step;

   always_comb begin
      trial     = {rem_ff, low_ff[QUO_W-1]};
      diff      = trial - {1'b0, dsr_ff};
      qbit      = (trial >= {1'b0, dsr_ff});
      rem_in    = qbit ? diff[DA_W-1:0] : trial[DA_W-1:0];
      last_step = run_ff && (cnt_ff == DIV_CNT_W'(QUO_W - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (div_req.start) begin
         run_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         if (last_step) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         // upper dividend bits start as the partial remainder
         rem_ff <= DA_W'(div_req.dividend[PROD_W-1:QUO_W]);
         low_ff <= div_req.dividend[QUO_W-1:0];
         dsr_ff <= div_req.divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[QUO_W-2:0], qbit};
      end
   end

   assign div_rsp.done     = last_step;
   assign div_rsp.quotient = {low_ff[QUO_W-2:0], qbit};

endmodule

`default_nettype wire

>>> rtl/bti_ctrl.sv
// ----------------------------------------------------------------------------
// bti_ctrl
// Command sequencer: table writes, segment scan over the table memory,
// difference and split multiply, range check, divider handoff and the
// saturating sum that forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bti_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_command,
   input  wire logic [bti_pkg::IDX_W-1:0]           req_point_index,
   input  wire logic signed [bti_pkg::TEMP_W-1:0]   req_point_temperature,
   input  wire logic signed [bti_pkg::ABS_W-1:0]    req_point_abscissa,
   input  wire logic signed [bti_pkg::ABS_W-1:0]    req_query_value,
   input  wire logic [bti_pkg::COUNT_W-1:0]         cfg_point_count,
   input  wire logic                                cfg_descending,
   output bti_pkg::mem_req_type                     mem_req,
   input  wire bti_pkg::mem_rsp_type                mem_rsp,
   output bti_pkg::div_req_type                     div_req,
   input  wire bti_pkg::div_rsp_type                div_rsp,
   output logic                                     rsp_strobe,
   output logic signed [bti_pkg::TEMP_W-1:0]        rsp_result_temperature,
   output bti_pkg::status_type                      rsp_status
);
   import bti_pkg::*;

   localparam logic [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
   localparam logic [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

   state_type           state_ff, state_in;
   logic                accept;
   logic [COUNT_W-1:0]  count_clamp;
   logic [ADDR_W-1:0]   last_idx;

   logic [ADDR_W-1:0]   issue_idx_ff;
   logic                issuing_ff;
   logic                chk_valid_ff;
   logic [ADDR_W-1:0]   chk_idx_ff;
   logic [ADDR_W-1:0]   seg_ff;
   logic [ADDR_W-1:0]   last_ff;
   logic signed [ABS_W-1:0]  v_ff;
   logic [TEMP_W-1:0]   t0_ff;
   logic [ABS_W-1:0]    a0_ff;
   logic [DT_W-1:0]     mdt_ff;
   logic [DA_W-1:0]     mdv_ff;
   logic [DA_W-1:0]     mda_ff;
   logic                neg_ff;
   logic [PROD_W-1:0]   prod_ff;

   logic                strobe_ff;
   logic [TEMP_W-1:0]   result_ff;
   status_type          status_ff;

   logic signed [ABS_W-1:0] a_rd;
   logic                hit_cmp;
   logic                scan_done;
   logic [DT_W-1:0]     dt;
   logic [DA_W-1:0]     dv;
   logic [DA_W-1:0]     da;
   logic                da_zero;
   logic [MUL_LO_W-1:0] mul_b;
   logic [MUL_OUT_W-1:0] mul_out;
   logic                over;
   logic [SUM_W-1:0]    q_ext;
   logic [SUM_W-1:0]    t0_ext;
   logic [SUM_W-1:0]    sum;
   logic [TEMP_W-1:0]   sum_sat;

   assign accept = start && !busy;

   always_comb begin
      count_clamp = (32'(cfg_point_count) > MAX_POINTS) ? COUNT_W'(MAX_POINTS)
                                                        : cfg_point_count;
      last_idx    = ADDR_W'(32'(count_clamp) - 1);
   end

   // datapath
   always_comb begin
      a_rd      = $signed(mem_rsp.rabsc);
      hit_cmp   = cfg_descending ? (v_ff > a_rd) : (v_ff < a_rd);
      scan_done = chk_valid_ff && ((chk_idx_ff == last_ff) || hit_cmp);

      dt      = {mem_rsp.rtemp[TEMP_W-1], mem_rsp.rtemp} - {t0_ff[TEMP_W-1], t0_ff};
      dv      = {v_ff[ABS_W-1], v_ff} - {a0_ff[ABS_W-1], a0_ff};
      da      = {mem_rsp.rabsc[ABS_W-1], mem_rsp.rabsc} - {a0_ff[ABS_W-1], a0_ff};
      da_zero = (da == '0);

      mul_b   = (state_ff == ST_MUL_HI) ? MUL_LO_W'(mdv_ff[DA_W-1:MUL_LO_W])
                                        : mdv_ff[MUL_LO_W-1:0];
      mul_out = MUL_OUT_W'(mdt_ff) * MUL_OUT_W'(mul_b);

      // quotient reaches 2^QUO_W exactly when the product reaches d << QUO_W
      over    = ((DA_W + QUO_W)'(prod_ff)) >= {mda_ff, {QUO_W{1'b0}}};

      q_ext   = {2'b00, div_rsp.quotient};
      t0_ext  = {{(SUM_W-TEMP_W){t0_ff[TEMP_W-1]}}, t0_ff};
      sum     = t0_ext + (neg_ff ? (~q_ext + SUM_W'(1)) : q_ext);
      if (sum[SUM_W-1] && !(&sum[SUM_W-2:TEMP_W-1])) begin
         sum_sat = TEMP_MIN;
      end else if (!sum[SUM_W-1] && (|sum[SUM_W-2:TEMP_W-1])) begin
         sum_sat = TEMP_MAX;
      end else begin
         sum_sat = sum[TEMP_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_QUERY) && (count_clamp > COUNT_W'(1))) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_RD_LO;
            end
         end
         ST_RD_LO:  state_in = ST_RD_HI;
         ST_RD_HI:  state_in = ST_DIFF;
         ST_DIFF:   state_in = da_zero ? ST_IDLE : ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_CHECK;
         ST_CHECK:  state_in = over ? ST_IDLE : ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      mem_req.we    = accept && (req_command == CMD_WRITE) &&
                      (32'(req_point_index) < MAX_POINTS);
      mem_req.waddr = ADDR_W'(req_point_index);
      mem_req.wtemp = req_point_temperature;
      mem_req.wabsc = req_point_abscissa;
      case (state_ff)
         ST_SCAN:  mem_req.raddr = issue_idx_ff;
         ST_RD_LO: mem_req.raddr = seg_ff - ADDR_W'(1);
         default:  mem_req.raddr = seg_ff;
      endcase
      div_req.start    = (state_ff == ST_CHECK) && !over;
      div_req.dividend = prod_ff;
      div_req.divisor  = mda_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issuing_ff   <= 1'b0;
         chk_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_command == CMD_WRITE || count_clamp < COUNT_W'(2)) begin
                     strobe_ff <= 1'b1;
                  end
                  issuing_ff   <= 1'b1;
                  chk_valid_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               chk_valid_ff <= issuing_ff;
               if (issuing_ff && issue_idx_ff == last_ff) begin
                  issuing_ff <= 1'b0;
               end
               if (scan_done) begin
                  issuing_ff <= 1'b0;
               end
            end
            ST_DIFF: begin
               if (da_zero) begin
                  strobe_ff <= 1'b1;
               end
            end
            ST_CHECK: begin
               if (over) begin
                  strobe_ff <= 1'b1;
               end
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  strobe_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            result_ff    <= '0;
            v_ff         <= req_query_value;
            last_ff      <= last_idx;
            issue_idx_ff <= ADDR_W'(1);
            if (req_command == CMD_WRITE) begin
               status_ff <= STAT_OK;
            end else if (count_clamp == '0) begin
               status_ff <= STAT_EMPTY;
            end else begin
               status_ff <= STAT_SINGLE;
            end
         end
         ST_SCAN: begin
            chk_idx_ff <= issue_idx_ff;
            if (issuing_ff && issue_idx_ff != last_ff) begin
               issue_idx_ff <= issue_idx_ff + ADDR_W'(1);
            end
            if (scan_done) begin
               seg_ff <= chk_idx_ff;
            end
         end
         ST_RD_HI: begin
            // data of the segment's lower breakpoint
            t0_ff <= mem_rsp.rtemp;
            a0_ff <= mem_rsp.rabsc;
         end
         ST_DIFF: begin
            mdt_ff    <= dt[DT_W-1] ? (~dt + DT_W'(1)) : dt;
            mdv_ff    <= dv[DA_W-1] ? (~dv + DA_W'(1)) : dv;
            mda_ff    <= da[DA_W-1] ? (~da + DA_W'(1)) : da;
            neg_ff    <= dt[DT_W-1] ^ dv[DA_W-1] ^ da[DA_W-1];
            result_ff <= '0;
            status_ff <= da_zero ? STAT_EQUAL : STAT_OK;
         end
         ST_MUL_LO: begin
            prod_ff <= PROD_W'(mul_out);
         end
         ST_MUL_HI: begin
            prod_ff <= prod_ff + (PROD_W'(mul_out) << MUL_LO_W);
         end
         ST_CHECK: begin
            result_ff <= neg_ff ? TEMP_MIN : TEMP_MAX;
         end
         ST_DIV: begin
            result_ff <= sum_sat;
         end
         default: ;
      endcase
   end

   assign rsp_strobe             = strobe_ff;
   assign rsp_result_temperature = $signed(result_ff);
   assign rsp_status             = status_ff;

endmodule

`default_nettype wire

>>> rtl/breakpoint_table_interpolator_unit.sv
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator_unit
// Piecewise-linear interpolation over a table of breakpoints held in a
// synchronous memory; configuration registers and the top-level wiring.
//
//   channel   handshake              payload
//   -------   --------------------   -----------------------------------------
//   req       start && !busy         command, point index/temperature/abscissa,
//                                    query value
//   rsp       rsp_strobe (1 cycle)   result temperature, status
//   csr       csr_valid && csr_ready register index, write data
//
// A write item or a query on fewer than two points answers in the cycle
// after it is taken. A query keeps busy high through the scan, which reads
// one abscissa per cycle from the memory port, the segment reads,
// differences, split multiply and range check, and the one-bit-per-cycle
// divider; its result shows in the same cycle that busy falls. Equal
// abscissae end the query after the difference step, a saturating quotient
// after the range check. Reset is synchronous and clears control state and
// the registers; the table is undefined until written. The receiver cannot
// stall, so a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_table_interpolator_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_command,
   input  wire logic [bti_pkg::IDX_W-1:0]            req_point_index,
   input  wire logic signed [bti_pkg::TEMP_W-1:0]    req_point_temperature,
   input  wire logic signed [bti_pkg::ABS_W-1:0]     req_point_abscissa,
   input  wire logic signed [bti_pkg::ABS_W-1:0]     req_query_value,
   output logic                                      rsp_strobe,
   output logic signed [bti_pkg::TEMP_W-1:0]         rsp_result_temperature,
   output logic [1:0]                                rsp_status,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bti_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [bti_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import bti_pkg::*;

   logic [COUNT_W-1:0] point_count_ff;
   logic               desc_mode_ff;
   mem_req_type        mem_req;
   mem_rsp_type        mem_rsp;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   status_type         status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         desc_mode_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POINT_COUNT: point_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_DESC_MODE:   desc_mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   bti_ctrl u_ctrl (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_command            (req_command),
      .req_point_index        (req_point_index),
      .req_point_temperature  (req_point_temperature),
      .req_point_abscissa     (req_point_abscissa),
      .req_query_value        (req_query_value),
      .cfg_point_count        (point_count_ff),
      .cfg_descending         (desc_mode_ff),
      .mem_req                (mem_req),
      .mem_rsp                (mem_rsp),
      .div_req                (div_req),
      .div_rsp                (div_rsp),
      .rsp_strobe             (rsp_strobe),
      .rsp_result_temperature (rsp_result_temperature),
      .rsp_status             (status)
   );

   bti_table_mem u_table_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   bti_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_status = status;

endmodule

`default_nettype wire

>>> rtl/bti_checker.sv
// ----------------------------------------------------------------------------
// bti_checker
// Port-level checks on the interpolator: every taken item leads to work or
// a result, results appear only when work ends, errors carry a zero value.
// ----------------------------------------------------------------------------
`default_nettype none

module bti_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               rsp_strobe,
   input wire logic signed [bti_pkg::TEMP_W-1:0]  rsp_result_temperature,
   input wire logic [1:0]                         rsp_status
);
   import bti_pkg::*;

   // a taken item either answers at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe || busy)
      else $error("item taken without progress");

   // the end of a query coincides with its result
   a_fall_has_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_result_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // no result without a taken item or work in flight
   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy) || $past(busy))
      else $error("result without cause");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != STAT_OK) |-> rsp_result_temperature == '0)
      else $error("error status with nonzero value");

endmodule

bind breakpoint_table_interpolator_unit bti_checker u_checker (.*);

`default_nettype wire

>>> tb/breakpoint_table_interpolator_unit_tb.sv
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator_unit_tb
// Self-checking bench for the breakpoint table interpolator. A short directed
// run covers the status codes, table extremes, extrapolation at both ends and
// saturation; random phases then load whole tables (sorted, coarse, with
// repeated abscissae, or scrambled), change point count and search direction
// while idle, and interleave queries with slot rewrites. Every result is
// checked against a local interpolation model in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_table_interpolator_unit_tb;
   import bti_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = CSR_INDEX_W'(15);
   localparam logic signed [ABS_W-1:0] ABS_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [ABS_W-1:0] ABS_MIN = 48'sh8000_0000_0000;
   localparam logic signed [127:0] TEMP_CEIL = 128'sd2147483647;
   localparam logic signed [127:0] TEMP_FLOOR = -128'sd2147483648;

   typedef struct packed {
      logic                     command;
      logic [IDX_W-1:0]         point_index;
      logic signed [TEMP_W-1:0] point_temperature;
      logic signed [ABS_W-1:0]  point_abscissa;
      logic signed [ABS_W-1:0]  query_value;
      logic [3:0]               gap;
      logic                     drain;
   } table_item_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      status_type               status;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_command = 1'b0;
   logic [IDX_W-1:0] req_point_index = '0;
   logic signed [TEMP_W-1:0] req_point_temperature = '0;
   logic signed [ABS_W-1:0] req_point_abscissa = '0;
   logic signed [ABS_W-1:0] req_query_value = '0;
   logic rsp_strobe;
   logic signed [TEMP_W-1:0] rsp_result_temperature;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // local copy of the block's state
   logic signed [TEMP_W-1:0] temp_table [MAX_POINTS];
   logic signed [ABS_W-1:0]  absc_table [MAX_POINTS];
   logic [COUNT_W-1:0]       cfg_point_count = '0;
   logic                     cfg_descending = 1'b0;

   table_item_type item_queue[$];
   answer_type     pending_answers[$];
   table_item_type cur_item = '0;
   bit          holding = 1'b0;
   int          gap_left = 0;
   int          mismatch_count = 0;
   bit          burst_phase = 1'b0;
   longint      plan_absc [MAX_POINTS];

   breakpoint_table_interpolator_unit dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_command            (req_command),
      .req_point_index        (req_point_index),
      .req_point_temperature  (req_point_temperature),
      .req_point_abscissa     (req_point_abscissa),
      .req_query_value        (req_query_value),
      .rsp_strobe             (rsp_strobe),
      .rsp_result_temperature (rsp_result_temperature),
      .rsp_status             (rsp_status),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always #4 clock = ~clock;

   // Apply one item to the local state and return the answer it must produce.
   function automatic answer_type interpolate_item(input table_item_type it);
      answer_type r;
      int n;
      int k;
      logic signed [127:0] t0, dt, dv, da, quo, sum;
      r.temperature = '0;
      r.status = STAT_OK;
      if (it.command == CMD_WRITE) begin
         temp_table[it.point_index] = it.point_temperature;
         absc_table[it.point_index] = it.point_abscissa;
      end else begin
         n = (int'(cfg_point_count) > MAX_POINTS) ? MAX_POINTS : int'(cfg_point_count);
         if (n == 0) begin
            r.status = STAT_EMPTY;
         end else if (n == 1) begin
            r.status = STAT_SINGLE;
         end else begin
            k = 1;
            while (k < n - 1 && !(cfg_descending ? (it.query_value > absc_table[k])
                                                 : (it.query_value < absc_table[k])))
               k++;
            t0 = temp_table[k-1];
            dt = temp_table[k] - t0;
            dv = it.query_value - absc_table[k-1];
            da = absc_table[k] - absc_table[k-1];
            if (da == 0) begin
               r.status = STAT_EQUAL;
            end else begin
               quo = (dt * dv) / da;
               sum = t0 + quo;
               if (sum > TEMP_CEIL) r.temperature = 32'sh7FFF_FFFF;
               else if (sum < TEMP_FLOOR) r.temperature = 32'sh8000_0000;
               else r.temperature = sum[TEMP_W-1:0];
            end
         end
      end
      return r;
   endfunction

   // driver: present queued items, hold each until taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            pending_answers.insert(pending_answers.size(), interpolate_item(cur_item));
            holding = 1'b0;
         end
         if (!holding && item_queue.size() > 0 &&
             !(item_queue[0].drain && pending_answers.size() > 0)) begin
            cur_item = item_queue.pop_front();
            holding = 1'b1;
            gap_left = cur_item.gap;
         end
         if (holding && gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else begin
            start <= holding;
         end
         req_command <= cur_item.command;
         req_point_index <= cur_item.point_index;
         req_point_temperature <= cur_item.point_temperature;
         req_point_abscissa <= cur_item.point_abscissa;
         req_query_value <= cur_item.query_value;
      end
   end

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (mismatch_count < 10)
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
      mismatch_count++;
   endtask

   // monitor: every strobe retires the oldest expected answer
   always @(posedge clock) begin : monitor_blk
      answer_type want;
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) begin
            flag_mismatch("unexpected result", '0, rsp_result_temperature);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_result_temperature !== want.temperature)
               flag_mismatch("result_temperature", want.temperature, rsp_result_temperature);
            if (rsp_status !== want.status)
               flag_mismatch("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   function automatic logic signed [ABS_W-1:0] rand48();
      logic [63:0] u;
      u = {$urandom, $urandom};
      return u[ABS_W-1:0];
   endfunction

   function automatic logic signed [TEMP_W-1:0] rand_temp();
      logic signed [TEMP_W-1:0] t;
      t = $urandom;
      if ($urandom_range(0, 3) != 0) t = t >>> $urandom_range(4, 24);
      return t;
   endfunction

   function automatic logic [3:0] draw_gap();
      return burst_phase ? 4'd0 : 4'($urandom_range(0, 12));
   endfunction

   task automatic queue_write(input logic [IDX_W-1:0] idx, input logic signed [TEMP_W-1:0] t,
                              input logic signed [ABS_W-1:0] a);
      table_item_type it;
      it.command = CMD_WRITE;
      it.point_index = idx;
      it.point_temperature = t;
      it.point_abscissa = a;
      it.query_value = rand48();
      it.gap = draw_gap();
      it.drain = ($urandom_range(0, 63) == 0);
      item_queue.insert(item_queue.size(), it);
   endtask

   task automatic queue_query(input logic signed [ABS_W-1:0] v);
      table_item_type it;
      it.command = CMD_QUERY;
      it.point_index = $urandom;
      it.point_temperature = $urandom;
      it.point_abscissa = rand48();
      it.query_value = v;
      it.gap = draw_gap();
      it.drain = ($urandom_range(0, 63) == 0);
      item_queue.insert(item_queue.size(), it);
   endtask

   task automatic wait_idle();
      while (item_queue.size() > 0 || holding || pending_answers.size() > 0)
         @(posedge clock);
   endtask

   // random upper bits ride along; only the low bits of each register count
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int value);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      if (idx == CSR_POINT_COUNT) word[COUNT_W-1:0] = value[COUNT_W-1:0];
      else if (idx == CSR_DESC_MODE) word[0] = value[0];
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= word;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid <= 1'b0;
      if (idx == CSR_POINT_COUNT) cfg_point_count = word[COUNT_W-1:0];
      else if (idx == CSR_DESC_MODE) cfg_descending = word[0];
   endtask

   // Load all slots; sorted in the search direction unless scrambled.
   task automatic fill_table(input bit desc, input int style);
      longint a, step;
      logic [63:0] u;
      int k, width;
      width = (style == 1) ? 41 : $urandom_range(2, 30);
      if (style == 1) a = desc ? longint'(ABS_MAX) : longint'(ABS_MIN);
      else a = longint'(rand48()) / 4;
      for (k = 0; k < MAX_POINTS; k++) begin
         if (style == 3) a = longint'(rand48()) >>> $urandom_range(0, 40);
         plan_absc[k] = a;
         queue_write(IDX_W'(k), rand_temp(), a[ABS_W-1:0]);
         u = {$urandom, $urandom};
         step = longint'(u & ((64'd1 << width) - 1)) + 1;
         if (style == 2 && $urandom_range(0, 3) == 0) step = 0;
         a = desc ? a - step : a + step;
      end
   endtask

   // Mostly inside the active span with some margin, sometimes on a
   // breakpoint, sometimes anywhere.
   function automatic logic signed [ABS_W-1:0] pick_query(input longint lo, input longint hi,
                                                          input int n);
      logic [63:0] u;
      longint margin, v;
      case ($urandom_range(0, 9))
         0: return rand48();
         1: return plan_absc[$urandom_range(0, n - 1)][ABS_W-1:0];
         default: begin
            margin = (hi - lo) / 4 + 1;
            u = {$urandom, $urandom};
            v = lo - margin + longint'(u % 64'(hi - lo + 2 * margin));
            if (v > longint'(ABS_MAX)) v = longint'(ABS_MAX);
            if (v < longint'(ABS_MIN)) v = longint'(ABS_MIN);
            return v[ABS_W-1:0];
         end
      endcase
   endfunction

   task automatic run_phase(input int count, input bit desc, input int style);
      longint lo, hi;
      int n, k, j;
      burst_phase = ($urandom_range(0, 3) == 0);
      fill_table(desc, style);
      wait_idle();
      write_csr(CSR_POINT_COUNT, count);
      write_csr(CSR_DESC_MODE, int'(desc));
      n = (count > MAX_POINTS) ? MAX_POINTS : count;
      lo = plan_absc[0];
      hi = plan_absc[0];
      for (k = 1; k < n; k++) begin
         if (plan_absc[k] < lo) lo = plan_absc[k];
         if (plan_absc[k] > hi) hi = plan_absc[k];
      end
      for (k = 0; k < 128; k++) begin
         if ($urandom_range(0, 7) == 0) begin
            j = $urandom_range(0, MAX_POINTS - 1);
            if ($urandom_range(0, 3) == 0) plan_absc[j] = longint'(rand48());
            queue_write(IDX_W'(j), rand_temp(), plan_absc[j][ABS_W-1:0]);
         end else begin
            queue_query(pick_query(lo, hi, n));
         end
      end
      wait_idle();
   endtask

   initial begin : stimulus
      int p;
      int counts [8] = '{64, 127, 2, 65, 40, 3, 64, 17};
      bit descs [8] = '{0, 1, 1, 0, 1, 0, 1, 0};
      int styles [8] = '{0, 1, 2, 3, 0, 2, 1, 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty table straight out of reset, then a small known table
      queue_query(rand48());
      queue_write(6'd0, 32'sd25600, 48'sd0);
      queue_write(6'd1, 32'sd51200, 48'sd1000);
      queue_write(6'd2, 32'sd76800, 48'sd1000);
      queue_write(6'd3, 32'sh7FFF_FFFF, 48'sd2000);
      queue_write(6'd4, 32'sh8000_0000, ABS_MAX);
      queue_write(6'd5, -32'sd1, ABS_MIN);
      wait_idle();
      write_csr(CSR_UNMAPPED, $urandom);
      write_csr(CSR_POINT_COUNT, 1);
      queue_query(ABS_MAX);
      wait_idle();
      // one segment: inside, below, and saturating at both ends
      write_csr(CSR_POINT_COUNT, 2);
      queue_query(48'sd500);
      queue_query(-48'sd5000);
      queue_query(ABS_MAX);
      queue_query(ABS_MIN);
      wait_idle();
      // last segment has equal abscissae
      write_csr(CSR_POINT_COUNT, 3);
      queue_query(48'sd5000);
      queue_query(48'sd500);
      wait_idle();
      write_csr(CSR_POINT_COUNT, 6);
      queue_query(48'sd1500);
      queue_query(48'sd1000000);
      queue_query(ABS_MIN);
      queue_query(ABS_MAX);
      wait_idle();
      write_csr(CSR_DESC_MODE, 1);
      queue_query(48'sd500);
      queue_query(48'sd1500);
      queue_query(ABS_MIN);
      wait_idle();

      for (p = 0; p < 8; p++)
         run_phase(counts[p], descs[p], styles[p]);

      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #8000000;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
